>>> src/csrf_pkg.sv
// ----------------------------------------------------------------------------
// csrf_pkg
// Shared types and constants of the RV32 CSR file: CSR numbers, view masks,
// storage slot map and the decoded access descriptor.
// ----------------------------------------------------------------------------
package csrf_pkg;

  // storage slot map
  localparam int unsigned SlotCount  = 24;
  localparam int unsigned SlotW      = $clog2(SlotCount);
  localparam int unsigned PlainCount = 20;
  localparam int unsigned PlainBase  = 4;

  localparam logic [SlotW-1:0] SLOT_FCSR    = SlotW'(0);
  localparam logic [SlotW-1:0] SLOT_MSTATUS = SlotW'(1);
  localparam logic [SlotW-1:0] SLOT_MIE     = SlotW'(2);
  localparam logic [SlotW-1:0] SLOT_MIP     = SlotW'(3);

  // csr numbers
  localparam logic [11:0] ADDR_FFLAGS   = 12'h001;
  localparam logic [11:0] ADDR_FRM      = 12'h002;
  localparam logic [11:0] ADDR_FCSR     = 12'h003;
  localparam logic [11:0] ADDR_SSTATUS  = 12'h100;
  localparam logic [11:0] ADDR_SIE      = 12'h104;
  localparam logic [11:0] ADDR_SIP      = 12'h144;
  localparam logic [11:0] ADDR_MSTATUS  = 12'h300;
  localparam logic [11:0] ADDR_MIE      = 12'h304;
  localparam logic [11:0] ADDR_MIP      = 12'h344;
  localparam logic [11:0] ADDR_CYCLE    = 12'hC00;
  localparam logic [11:0] ADDR_TIME     = 12'hC01;
  localparam logic [11:0] ADDR_INSTRET  = 12'hC02;
  localparam logic [11:0] ADDR_CYCLEH   = 12'hC80;
  localparam logic [11:0] ADDR_TIMEH    = 12'hC81;
  localparam logic [11:0] ADDR_INSTRETH = 12'hC82;

  // plain stores, in slot order after the fixed slots
  localparam logic [11:0] PLAIN_ADDR [PlainCount] = '{
    12'h106, 12'h105, 12'h140, 12'h141, 12'h142, 12'h143, 12'h180,
    12'h301, 12'h306, 12'h302, 12'h303, 12'h305, 12'h340, 12'h341,
    12'h342, 12'h343, 12'hF11, 12'hF12, 12'hF13, 12'hF14
  };

  // field masks
  localparam logic [31:0] MASK_FULL    = 32'hFFFF_FFFF;
  localparam logic [31:0] MASK_SSTATUS = 32'h000C_0122;
  localparam logic [31:0] MASK_SINTR   = 32'h0000_0222;
  localparam logic [31:0] MASK_FFLAGS  = 32'h0000_001F;
  localparam logic [31:0] MASK_FRM     = 32'h0000_0007;
  localparam logic [31:0] MASK_FCSR    = 32'h0000_00FF;
  localparam int unsigned FrmShift     = 5;

  typedef enum logic [1:0] {
    CNT_CYCLE,
    CNT_TIME,
    CNT_INSTRET
  } csrf_cnt_e;

  // decoded access descriptor
  typedef struct packed {
    logic             hit;      // address maps to a storage slot
    logic [SlotW-1:0] slot;
    logic [31:0]      mask;     // field mask before the shift
    logic             frm;      // field sits at the frm position
    logic             cnt;      // address is a counter view
    csrf_cnt_e        cnt_sel;
    logic             cnt_hi;
  } csrf_dec_t;

endpackage

>>> src/riscv_csr_file_access.sv
// ----------------------------------------------------------------------------
// riscv_csr_file_access
// RV32 control and status register file with read and write accesses.
// ----------------------------------------------------------------------------
// An access item is taken at a rising edge with start high and busy low;
// busy stays low, so one access can be issued every cycle.
// The item carries func_i (0 read, 1 write), csr_addr_i, write_value_i and
// the three 64-bit counters sampled at that same edge.
// In the cycle after acceptance, done_o is high for exactly one cycle and
// read_data_o holds the CSR value of a read, or zero for a write or an
// unimplemented address. Throughput is one access per cycle: the storage
// memory has registered read data, and the read-modify-write follows in
// the next cycle; a write to the slot that the next access reads is
// forwarded around the memory.
// fflags, frm and fcsr share one slot; sstatus, sie and sip are masked
// views of the mstatus, mie and mip slots. Counters read as halves and
// ignore writes.
// Reset clears the per-slot valid bits at once, so every stored CSR reads as zero
// right after reset with no clearing pass. The receiver cannot stall:
// each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module riscv_csr_file_access (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [11:0] csr_addr_i,
  input  logic [31:0] write_value_i,
  input  logic [63:0] cycle_count_i,
  input  logic [63:0] time_count_i,
  input  logic [63:0] retired_count_i,
  output logic        done_o,
  output logic [31:0] read_data_o
);

  csrf_pkg::csrf_dec_t dec;

  logic                       s1_valid_q;
  logic                       s1_write_q;
  logic                       s1_hit_q;
  logic                       s1_cnt_q;
  logic                       s1_frm_q;
  logic [csrf_pkg::SlotW-1:0] s1_slot_q;
  logic [31:0]                s1_mask_q;
  logic [31:0]                s1_wval_q;
  logic [31:0]                s1_cnt_val_q;
  logic [31:0]                cnt_val_d;

  logic                       accept;
  logic [31:0]                entry;
  logic [31:0]                field_rd;
  logic [31:0]                mask_pos;
  logic [31:0]                wval_pos;
  logic [31:0]                merged;
  logic                       wr_en;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  csrf_decode u_decode (
    .csr_addr_i (csr_addr_i),
    .dec_o      (dec)
  );

  // counter half selection at acceptance
  always_comb begin
    logic [63:0] full;
    case (dec.cnt_sel)
      csrf_pkg::CNT_CYCLE:   full = cycle_count_i;
      csrf_pkg::CNT_TIME:    full = time_count_i;
      csrf_pkg::CNT_INSTRET: full = retired_count_i;
      default:               full = '0;
    endcase
    cnt_val_d = dec.cnt_hi ? full[63:32] : full[31:0];
  end

  // stage one control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_write_q   <= func_i;
      s1_hit_q     <= dec.hit;
      s1_cnt_q     <= dec.cnt;
      s1_frm_q     <= dec.frm;
      s1_slot_q    <= dec.slot;
      s1_mask_q    <= dec.mask;
      s1_wval_q    <= write_value_i;
      s1_cnt_val_q <= cnt_val_d;
    end
  end

  csrf_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_slot_i (dec.slot),
    .wr_en_i   (wr_en),
    .wr_slot_i (s1_slot_q),
    .wr_data_i (merged),
    .rd_data_o (entry)
  );

  // field extract and merge under the view mask
  always_comb begin
    if (s1_frm_q) begin
      field_rd = (entry >> csrf_pkg::FrmShift) & s1_mask_q;
      mask_pos = s1_mask_q << csrf_pkg::FrmShift;
      wval_pos = (s1_wval_q & s1_mask_q) << csrf_pkg::FrmShift;
    end else begin
      field_rd = entry & s1_mask_q;
      mask_pos = s1_mask_q;
      wval_pos = s1_wval_q & s1_mask_q;
    end
    merged = (entry & ~mask_pos) | wval_pos;
  end

  assign wr_en = s1_valid_q && s1_write_q && s1_hit_q;

  // result
  assign done_o      = s1_valid_q;
  assign read_data_o = s1_write_q ? '0           :
                       s1_cnt_q   ? s1_cnt_val_q :
                       s1_hit_q   ? field_rd     : '0;

endmodule

>>> src/csrf_decode.sv
// ----------------------------------------------------------------------------
// csrf_decode
// Maps a CSR number to its storage slot, field mask and counter view.
// ----------------------------------------------------------------------------
module csrf_decode (
  input  logic [11:0]        csr_addr_i,
  output csrf_pkg::csrf_dec_t dec_o
);

  always_comb begin
    dec_o         = '0;
    dec_o.mask    = csrf_pkg::MASK_FULL;
    dec_o.cnt_sel = csrf_pkg::CNT_CYCLE;

    // plain stores
    for (int i = 0; i < csrf_pkg::PlainCount; i++) begin
      if (csr_addr_i == csrf_pkg::PLAIN_ADDR[i]) begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SlotW'(csrf_pkg::PlainBase + i);
      end
    end

    // views and counters
    case (csr_addr_i)
      csrf_pkg::ADDR_FFLAGS: begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SLOT_FCSR;
        dec_o.mask = csrf_pkg::MASK_FFLAGS;
      end
      csrf_pkg::ADDR_FRM: begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SLOT_FCSR;
        dec_o.mask = csrf_pkg::MASK_FRM;
        dec_o.frm  = 1'b1;
      end
      csrf_pkg::ADDR_FCSR: begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SLOT_FCSR;
        dec_o.mask = csrf_pkg::MASK_FCSR;
      end
      csrf_pkg::ADDR_SSTATUS: begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SLOT_MSTATUS;
        dec_o.mask = csrf_pkg::MASK_SSTATUS;
      end
      csrf_pkg::ADDR_SIE: begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SLOT_MIE;
        dec_o.mask = csrf_pkg::MASK_SINTR;
      end
      csrf_pkg::ADDR_SIP: begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SLOT_MIP;
        dec_o.mask = csrf_pkg::MASK_SINTR;
      end
      csrf_pkg::ADDR_MSTATUS: begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SLOT_MSTATUS;
      end
      csrf_pkg::ADDR_MIE: begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SLOT_MIE;
      end
      csrf_pkg::ADDR_MIP: begin
        dec_o.hit  = 1'b1;
        dec_o.slot = csrf_pkg::SLOT_MIP;
      end
      csrf_pkg::ADDR_CYCLE: begin
        dec_o.cnt = 1'b1;
      end
      csrf_pkg::ADDR_TIME: begin
        dec_o.cnt     = 1'b1;
        dec_o.cnt_sel = csrf_pkg::CNT_TIME;
      end
      csrf_pkg::ADDR_INSTRET: begin
        dec_o.cnt     = 1'b1;
        dec_o.cnt_sel = csrf_pkg::CNT_INSTRET;
      end
      csrf_pkg::ADDR_CYCLEH: begin
        dec_o.cnt    = 1'b1;
        dec_o.cnt_hi = 1'b1;
      end
      csrf_pkg::ADDR_TIMEH: begin
        dec_o.cnt     = 1'b1;
        dec_o.cnt_sel = csrf_pkg::CNT_TIME;
        dec_o.cnt_hi  = 1'b1;
      end
      csrf_pkg::ADDR_INSTRETH: begin
        dec_o.cnt     = 1'b1;
        dec_o.cnt_sel = csrf_pkg::CNT_INSTRET;
        dec_o.cnt_hi  = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> src/csrf_store.sv
// ----------------------------------------------------------------------------
// csrf_store
// Synchronous CSR storage: one read and one write port, registered read
// data, per-entry valid bits for reset-to-zero and write-to-read bypass.
// ----------------------------------------------------------------------------
module csrf_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [csrf_pkg::SlotW-1:0] rd_slot_i,
  input  logic                       wr_en_i,
  input  logic [csrf_pkg::SlotW-1:0] wr_slot_i,
  input  logic [31:0]                wr_data_i,
  output logic [31:0]                rd_data_o
);

  logic [31:0]                  mem_q [csrf_pkg::SlotCount];
  logic [csrf_pkg::SlotCount-1:0] valid_q;
  logic [31:0]                  rd_q;
  logic                         rd_valid_q;
  logic                         byp_q;
  logic [31:0]                  byp_data_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_slot_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_slot_i];
      byp_data_q <= wr_data_i;
    end
  end

  // valid bits and bypass flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_slot_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_slot_i];
        byp_q      <= wr_en_i && (wr_slot_i == rd_slot_i);
      end
    end
  end

  // unwritten entries read as zero
  assign rd_data_o = byp_q      ? byp_data_q :
                     rd_valid_q ? rd_q       : '0;

endmodule
